// ===== rtl/core/eia_pkg.sv =====
// Shared types, constants and controller/datapath interface structs for the ID allocator.
`default_nettype none

package eia_pkg;

    // Sizing
    localparam int ID_COUNT = 64;
    localparam int SIG_BITS = 32;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int CNT_W    = $clog2(ID_COUNT + 1);

    // Request codes
    localparam logic [2:0] REQ_ALLOC  = 3'd0;
    localparam logic [2:0] REQ_FREE   = 3'd1;
    localparam logic [2:0] REQ_ADD    = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [SIG_BITS-1:0] t_sig;

    // Request transaction
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  entity_id;
        logic [31:0] sig_mask;
    } t_req;

    // Response transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  new_id;
        logic [31:0] sig_out;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       set_status;
        logic [1:0] status_val;
        logic       ord_rd_count;
        logic       alloc_commit;
        logic       scan_clear;
        logic       scan_issue;
        logic       scan_active;
        logic       free_commit;
        logic       sig_rd;
        logic       sig_commit;
        logic       out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic is_mask;
        logic id_ok;
        logic full;
        logic idx_at_count;
        logic rd_pending;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/eia_dpath.sv =====
// Datapath: ID order memory, mask memory, allocation count, scan logic and output register.
`default_nettype none

module eia_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire eia_pkg::t_req i_in_req,
    input  wire eia_pkg::t_cmd i_cmd,
    input  wire logic          i_out_stall,
    output eia_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output eia_pkg::t_rsp      o_out_rsp
);

    // Captured request and working state
    eia_pkg::t_req r_req;
    eia_pkg::t_cnt r_count;
    eia_pkg::t_cnt r_idx;
    logic          r_found;
    eia_pkg::t_rsp r_rsp;
    logic          r_out_valid;
    eia_pkg::t_rsp r_out_rsp;

    // Order memory with per-entry valid bits (unwritten entry i reads as i)
    eia_pkg::t_id               r_ord_mem [eia_pkg::ID_COUNT];
    logic [eia_pkg::ID_COUNT-1:0] r_ord_vld;
    eia_pkg::t_id               r_ord_rd_data;
    logic                       r_ord_rd_hit;
    eia_pkg::t_id               r_ord_rd_addr;
    logic                       r_ord_pend;

    // Mask memory with per-entry valid bits (unwritten entry reads as zero)
    eia_pkg::t_sig              r_sig_mem [eia_pkg::ID_COUNT];
    logic [eia_pkg::ID_COUNT-1:0] r_sig_vld;
    eia_pkg::t_sig              r_sig_rd_data;
    logic                       r_sig_rd_hit;

    logic          id_in_range;
    eia_pkg::t_id  req_id;
    eia_pkg::t_id  ord_word;
    eia_pkg::t_sig sig_word;
    logic [63:0]   mask64;
    eia_pkg::t_sig mask_w;
    logic [63:0]   sig64;
    eia_pkg::t_cnt cnt_m1;
    logic          ord_rd_en;
    eia_pkg::t_id  ord_rd_addr;
    logic          ord_wr_en;
    eia_pkg::t_id  ord_wr_addr;
    eia_pkg::t_id  ord_wr_data;
    logic          shift_wr;
    logic          scan_hit;
    logic          sig_wr_en;
    eia_pkg::t_sig sig_wr_data;
    logic          out_free;

    // Request decode and read-data resolution
    assign id_in_range = {1'b0, r_req.entity_id} < 9'(eia_pkg::ID_COUNT);
    assign req_id      = r_req.entity_id[eia_pkg::ID_W-1:0];
    assign ord_word    = r_ord_rd_hit ? r_ord_rd_data : r_ord_rd_addr;
    assign sig_word    = r_sig_rd_hit ? r_sig_rd_data : '0;
    assign mask64      = {32'd0, r_req.sig_mask};
    assign mask_w      = mask64[eia_pkg::SIG_BITS-1:0];
    assign sig64       = 64'(sig_word);
    assign cnt_m1      = r_count - 1'b1;

    // Scan: entries past the freed ID move down one slot
    assign scan_hit = i_cmd.scan_active && r_ord_pend && !r_found && (ord_word == req_id);
    assign shift_wr = i_cmd.scan_active && r_ord_pend && r_found;

    // Order memory port control
    assign ord_rd_en   = i_cmd.ord_rd_count || i_cmd.scan_issue;
    assign ord_rd_addr = i_cmd.scan_issue ? r_idx[eia_pkg::ID_W-1:0]
                                          : r_count[eia_pkg::ID_W-1:0];
    always_comb begin
        ord_wr_en   = 1'b0;
        ord_wr_addr = r_ord_rd_addr - 1'b1;
        ord_wr_data = ord_word;
        if (shift_wr) begin
            ord_wr_en = 1'b1;
        end else if (i_cmd.free_commit && r_found) begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = cnt_m1[eia_pkg::ID_W-1:0];
            ord_wr_data = req_id;
        end
    end

    // Mask read-modify-write
    always_comb begin
        sig_wr_en   = 1'b0;
        sig_wr_data = sig_word | mask_w;
        if (i_cmd.sig_commit) begin
            case (r_req.req_type)
                eia_pkg::REQ_ADD: begin
                    sig_wr_en   = 1'b1;
                    sig_wr_data = sig_word | mask_w;
                end
                eia_pkg::REQ_REMOVE: begin
                    sig_wr_en   = 1'b1;
                    sig_wr_data = sig_word & ~mask_w;
                end
                default: begin
                    sig_wr_en = 1'b0;
                end
            endcase
        end
    end

    // Order memory array
    always_ff @(posedge i_clk) begin
        if (ord_wr_en) begin
            r_ord_mem[ord_wr_addr] <= ord_wr_data;
        end
        if (ord_rd_en) begin
            r_ord_rd_data <= r_ord_mem[ord_rd_addr];
            r_ord_rd_hit  <= r_ord_vld[ord_rd_addr];
            r_ord_rd_addr <= ord_rd_addr;
        end
    end

    // Mask memory array
    always_ff @(posedge i_clk) begin
        if (sig_wr_en) begin
            r_sig_mem[req_id] <= sig_wr_data;
        end
        if (i_cmd.sig_rd) begin
            r_sig_rd_data <= r_sig_mem[req_id];
            r_sig_rd_hit  <= r_sig_vld[req_id];
        end
    end

    // Valid bits, counters and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord_vld   <= '0;
            r_sig_vld   <= '0;
            r_count     <= '0;
            r_ord_pend  <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ord_wr_en) begin
                r_ord_vld[ord_wr_addr] <= 1'b1;
            end
            if (sig_wr_en) begin
                r_sig_vld[req_id] <= 1'b1;
            end
            r_ord_pend <= ord_rd_en;
            if (i_cmd.scan_clear) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (scan_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.alloc_commit) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.free_commit && r_found) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, response staging and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_req;
            r_rsp <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_rsp.status <= i_cmd.status_val;
            end
            if (i_cmd.alloc_commit) begin
                r_rsp.new_id <= 8'(ord_word);
            end
            if (i_cmd.free_commit && !r_found) begin
                r_rsp.status <= eia_pkg::ST_ABSENT;
            end
            if (i_cmd.sig_commit && (r_req.req_type == eia_pkg::REQ_READ)) begin
                r_rsp.sig_out <= sig64[31:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out_rsp <= r_rsp;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to controller
    assign o_sts.is_alloc     = (r_req.req_type == eia_pkg::REQ_ALLOC);
    assign o_sts.is_free      = (r_req.req_type == eia_pkg::REQ_FREE);
    assign o_sts.is_mask      = (r_req.req_type == eia_pkg::REQ_ADD)
                              || (r_req.req_type == eia_pkg::REQ_REMOVE)
                              || (r_req.req_type == eia_pkg::REQ_READ);
    assign o_sts.id_ok        = id_in_range;
    assign o_sts.full         = (r_count == eia_pkg::CNT_W'(eia_pkg::ID_COUNT));
    assign o_sts.idx_at_count = (r_idx == r_count);
    assign o_sts.rd_pending   = r_ord_pend;
    assign o_sts.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

// ===== rtl/core/eia_ctrl.sv =====
// Controller: state machine that sequences allocate, free scan and mask operations.
`default_nettype none

module eia_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire eia_pkg::t_sts i_sts,
    output logic               o_in_stall,
    output eia_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_DISPATCH   = 7'b0000010,
        S_ALLOC_WAIT = 7'b0000100,
        S_SCAN       = 7'b0001000,
        S_FREE_END   = 7'b0010000,
        S_MASK_WAIT  = 7'b0100000,
        S_RESP       = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status_val = eia_pkg::ST_FULL;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.ord_rd_count = 1'b1;
                        n_state            = S_ALLOC_WAIT;
                    end
                end else if (i_sts.is_free || i_sts.is_mask) begin
                    if (!i_sts.id_ok) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status_val = eia_pkg::ST_RANGE;
                        n_state          = S_RESP;
                    end else if (i_sts.is_free) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.sig_rd = 1'b1;
                        n_state      = S_MASK_WAIT;
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_ALLOC_WAIT: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = S_RESP;
            end
            S_SCAN: begin
                // one list entry read per cycle, shift writes use the registered read data
                o_cmd.scan_active = 1'b1;
                o_cmd.scan_issue  = !i_sts.idx_at_count;
                if (i_sts.idx_at_count && !i_sts.rd_pending) begin
                    n_state = S_FREE_END;
                end
            end
            S_FREE_END: begin
                o_cmd.free_commit = 1'b1;
                n_state           = S_RESP;
            end
            S_MASK_WAIT: begin
                o_cmd.sig_commit = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/entity_id_allocator.sv =====
// Flow: one transaction at a time; the next is accepted in the cycle after the response loads.
//   Rejected and unknown requests go from dispatch straight to the response; free walks the
//   list, one order-memory read per cycle, each shift write using the registered read data.
// Reset: synchronous active low; clears count, state machine and per-entry valid bits,
//   so the list reads as identity and all masks as zero at once, with no clearing pass.
`default_nettype none

module entity_id_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire eia_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output eia_pkg::t_rsp      o_out_rsp
);

    eia_pkg::t_cmd w_cmd;
    eia_pkg::t_sts w_sts;

    // Sequencer
    eia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Storage and response path
    eia_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

`ifndef NO_ASSERTIONS
    // An accepted transaction blocks the next one until its response is staged
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice without processing");

    // A response is only loaded into a free output slot
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("output register overwritten");

    // Allocation never commits past the end of the list
    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alloc_commit |-> !w_sts.full)
        else $error("allocate committed on a full list");

    // The free scan never runs while input is open
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_active |-> o_in_stall)
        else $error("scan active while idle");
`endif

endmodule

`default_nettype wire
